@@ rtl/core/ilid_pkg.sv @@
// Shared types and constants for the indexed list block.
package ilid_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int EC_W     = 7;
    localparam int CMP_W    = (COUNT_W > POS_W) ? COUNT_W : POS_W;
    localparam int IN_W     = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_W    = ((VAL_W + EC_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_FRONT  = 2'd0,
        OP_BACK   = 2'd1,
        OP_INSERT = 2'd2,
        OP_DUMP   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED    = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_FULL      = 3'd2,
        ST_ENTRY     = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_ROTATE = 2'd2
    } cell_cmd_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        cell_cmd_t          cmd;
        logic [COUNT_W-1:0] at;
        logic [COUNT_W-1:0] occ;
        logic [VAL_W-1:0]   value;
    } ilid_ctl_t;

endpackage

@@ rtl/core/indexed_list_insert_and_dump.sv @@
// Top level of the indexed list: sequencer, output register and cell chain.
//
// Usage:
//   Input transactions (s_*) carry the operation in s_tuser and the position
//   and new value in s_tdata. Each result leaves on m_*: status in m_tuser,
//   entry value and entry count in m_tdata, and m_tlast on the final result
//   of each input transaction.
//   The list lives in a chain of CAPACITY cells. An add or insert shifts the
//   tail back one cell in the same cycle the transaction is accepted; its
//   single result is valid on the next cycle. An input transaction is taken
//   every cycle while results drain, so adds and inserts run at one per cycle
//   while m_tready stays high. A dump rotates the occupied cells toward the
//   head, emitting cell 0 each cycle that the output register is free; once
//   every entry has gone out, the list is back in order. No input is accepted
//   during a dump. An empty list gives one result. The first result of every
//   transaction is valid on the cycle after acceptance.
//   A stall on m_tready holds the output register and the chain; s_tready
//   drops until the pending result is taken.
//   Reset clears the entry count and the control state; cell contents are not
//   cleared and are never read beyond the entry count.
module indexed_list_insert_and_dump (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ilid_pkg::IN_W-1:0]      s_tdata,  // position[6:0], new_value[38:7], pad
    input  logic [ilid_pkg::OP_W-1:0]      s_tuser,  // operation[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ilid_pkg::OUT_W-1:0]     m_tdata,  // entry_value[31:0], entry_count[38:32], pad
    output logic [ilid_pkg::STATUS_W-1:0]  m_tuser,  // status[2:0]
    output logic                           m_tlast   // last_of_run
);
    import ilid_pkg::*;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    state_t             state_reg;
    logic [COUNT_W-1:0] occ_reg;
    logic [COUNT_W-1:0] dump_cnt_reg;
    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [VAL_W-1:0]   m_value_reg;
    logic [EC_W-1:0]    m_count_reg;
    logic               m_last_reg;

    logic               out_free;
    logic               acc;
    op_t                in_op;
    logic [POS_W-1:0]   in_pos;
    logic [VAL_W-1:0]   in_val;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   occ_ext;
    logic [CMP_W-1:0]   target;
    logic               bad;
    logic               full;
    logic               do_store;
    logic               dump_start;
    logic               dump_step;
    logic               dump_last;
    logic [COUNT_W-1:0] occ_inc;
    logic [COUNT_W-1:0] dump_cnt_inc;
    ilid_ctl_t          ctl;
    logic [VAL_W-1:0]   cell_q [CAPACITY];

    // input field unpacking
    assign in_op  = op_t'(s_tuser);
    assign in_pos = s_tdata[POS_W-1:0];
    assign in_val = s_tdata[POS_W+VAL_W-1:POS_W];

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign acc       = s_tvalid && s_tready;

    assign pos_ext = CMP_W'(in_pos);
    assign occ_ext = CMP_W'(occ_reg);
    assign occ_inc = occ_reg + COUNT_W'(1);
    assign dump_cnt_inc = dump_cnt_reg + COUNT_W'(1);

    always_comb
    begin
        case (in_op)
            OP_FRONT: target = '0;
            OP_BACK:  target = occ_ext;
            default:  target = pos_ext;
        endcase
    end

    // index check comes before the full check
    assign bad        = (in_op == OP_INSERT) && (pos_ext > occ_ext);
    assign full       = (occ_reg == COUNT_W'(CAPACITY));
    assign do_store   = acc && (in_op != OP_DUMP) && !bad && !full;
    assign dump_start = acc && (in_op == OP_DUMP) && (occ_reg != '0);
    assign dump_step  = (state_reg == S_DUMP) && out_free;
    assign dump_last  = (dump_cnt_inc == occ_reg);

    // broadcast to the chain
    always_comb
    begin
        ctl.at    = target[COUNT_W-1:0];
        ctl.occ   = occ_reg;
        ctl.value = in_val;
        if (do_store)
            ctl.cmd = CMD_INSERT;
        else if (dump_start || dump_step)
            ctl.cmd = CMD_ROTATE;
        else
            ctl.cmd = CMD_HOLD;
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [VAL_W-1:0] left_val;
        logic [VAL_W-1:0] right_val;

        if (g == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_mid
            assign left_val = cell_q[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_val = '0;
        end
        else
        begin : g_body
            assign right_val = cell_q[g+1];
        end

        ilid_cell u_cell (
            .clk   (clk),
            .idx   (IDX_W'(g)),
            .ctl   (ctl),
            .left  (left_val),
            .right (right_val),
            .head  (cell_q[0]),
            .value (cell_q[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            dump_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
            m_status_reg <= ST_STORED;
            m_value_reg  <= '0;
            m_count_reg  <= '0;
            m_last_reg   <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        m_valid_reg <= 1'b1;
                        m_value_reg <= '0;
                        m_last_reg  <= 1'b1;
                        m_count_reg <= EC_W'(occ_reg);
                        if (in_op == OP_DUMP)
                        begin
                            if (occ_reg == '0)
                                m_status_reg <= ST_EMPTY;
                            else
                            begin
                                // first entry goes out now, the rest follow
                                m_status_reg <= ST_ENTRY;
                                m_value_reg  <= cell_q[0];
                                m_last_reg   <= (occ_reg == COUNT_W'(1));
                                dump_cnt_reg <= COUNT_W'(1);
                                if (occ_reg != COUNT_W'(1))
                                    state_reg <= S_DUMP;
                            end
                        end
                        else if (bad)
                            m_status_reg <= ST_BAD_INDEX;
                        else if (full)
                            m_status_reg <= ST_FULL;
                        else
                        begin
                            m_status_reg <= ST_STORED;
                            m_count_reg  <= EC_W'(occ_inc);
                            occ_reg      <= occ_inc;
                        end
                    end
                end
                S_DUMP:
                begin
                    if (out_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= ST_ENTRY;
                        m_value_reg  <= cell_q[0];
                        m_last_reg   <= dump_last;
                        dump_cnt_reg <= dump_cnt_inc;
                        if (dump_last)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = OUT_W'({m_count_reg, m_value_reg});

    // count never passes the chain length
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a successful store grows the list by exactly one
    a_store_grow: assert property (@(posedge clk) disable iff (!rst_n)
        do_store |=> occ_reg == $past(occ_inc))
        else $error("store did not grow the list");

    // the list does not change size while it is being dumped
    a_dump_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |=> $stable(occ_reg))
        else $error("entry count changed during dump");

    // non-entry results carry a zero value and close the run
    a_nonentry: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg != ST_ENTRY) |-> (m_last_reg && m_value_reg == '0))
        else $error("malformed status result");

endmodule

@@ rtl/core/ilid_cell.sv @@
// One list cell: holds a single entry and trades it with its neighbors.
module ilid_cell (
    input  logic                         clk,
    input  logic [ilid_pkg::IDX_W-1:0]   idx,
    input  ilid_pkg::ilid_ctl_t          ctl,
    input  logic [ilid_pkg::VAL_W-1:0]   left,
    input  logic [ilid_pkg::VAL_W-1:0]   right,
    input  logic [ilid_pkg::VAL_W-1:0]   head,
    output logic [ilid_pkg::VAL_W-1:0]   value
);
    import ilid_pkg::*;

    logic [VAL_W-1:0]   value_reg;
    logic [VAL_W-1:0]   value_next;
    logic [COUNT_W-1:0] idx_ext;
    logic [COUNT_W-1:0] idx_inc;

    assign idx_ext = COUNT_W'(idx);
    assign idx_inc = idx_ext + COUNT_W'(1);

    always_comb
    begin
        value_next = value_reg;
        case (ctl.cmd)
            CMD_INSERT:
            begin
                // target takes the new value, tail moves back one place
                if (idx_ext == ctl.at)
                    value_next = ctl.value;
                else if (idx_ext > ctl.at && idx_ext <= ctl.occ)
                    value_next = left;
            end
            CMD_ROTATE:
            begin
                // rotate the occupied part toward the head
                if (idx_inc < ctl.occ)
                    value_next = right;
                else if (idx_inc == ctl.occ)
                    value_next = head;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

@@ sim/indexed_list_insert_and_dump_tb.sv @@
// Self-checking testbench for the indexed list: directed and random stream traffic checked against a list model.
`timescale 1ns / 100ps

module indexed_list_insert_and_dump_tb;

    import ilid_pkg::*;

    // One planned input transaction. gap is the number of idle cycles before it is
    // offered; sync holds it back until every predicted result has been taken.
    typedef struct {
        op_t          op;
        logic [6:0]   pos;
        logic [31:0]  val;
        int unsigned  gap;
        bit           sync;
    } list_cmd_t;

    // One predicted result transaction.
    typedef struct {
        status_t      status;
        logic [31:0]  value;
        logic         last;
        logic [6:0]   count;
    } list_result_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata  = '0;   // position[6:0], new_value[38:7], pad
    logic [OP_W-1:0]       s_tuser  = OP_FRONT;   // operation[1:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;         // entry_value[31:0], entry_count[38:32], pad
    logic [STATUS_W-1:0]   m_tuser;         // status[2:0]
    logic                  m_tlast;

    indexed_list_insert_and_dump u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Planned stimulus, the list contents as the model sees them, and results still owed.
    list_cmd_t     pending_cmds[$];
    logic [31:0]   held_values[$];
    list_result_t  results_due[$];

    list_cmd_t     cur_cmd;
    list_result_t  due;
    int            planned_cnt = 0;
    int            plan_occ    = 0;     // occupancy seen by the planner, for shaping positions
    int            sent_cnt    = 0;     // accepted input transactions (nonblocking)
    int            got_count   = 0;     // accepted result transactions (nonblocking)
    int            exp_count   = 0;     // predicted result transactions
    int            error_count = 0;
    int unsigned   idle_cnt    = 0;
    int unsigned   stall_left  = 0;
    logic          tx_next;
    logic          rdy_next;
    logic          rx_hold     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the handshake locks up.
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 40)
            $display("ERROR t=%0t result #%0d %s: got %0h, expected %0h",
                     $time, got_count, what, got, want);
        error_count++;
    endtask

    task automatic queue_result(input status_t st, input logic [31:0] value, input logic last);
        list_result_t r;
        r.status = st;
        r.value  = value;
        r.last   = last;
        r.count  = 7'(held_values.size());   // entry count wraps at 7 bits
        results_due.push_back(r);
        exp_count++;
    endtask

    // List model: updates the held values for one accepted transaction and
    // queues every result it owes.
    task automatic apply_to_list(input list_cmd_t c);
        int n;
        n = held_values.size();
        if (c.op == OP_DUMP)
        begin
            if (n == 0)
                queue_result(ST_EMPTY, 32'd0, 1'b1);
            else
                for (int i = 0; i < n; i++)
                    queue_result(ST_ENTRY, held_values[i], i == n - 1);
            return;
        end
        // index check wins over the full check
        if (c.op == OP_INSERT && int'(c.pos) > n)
            queue_result(ST_BAD_INDEX, 32'd0, 1'b1);
        else if (n >= CAPACITY)
            queue_result(ST_FULL, 32'd0, 1'b1);
        else
        begin
            case (c.op)
                OP_FRONT: held_values.push_front(c.val);
                OP_BACK:  held_values.push_back(c.val);
                default:  held_values.insert(int'(c.pos), c.val);
            endcase
            queue_result(ST_STORED, 32'd0, 1'b1);
        end
    endtask

    // Planner: appends a transaction and tracks whether it would store a value.
    task automatic plan_cmd(input op_t op, input logic [6:0] pos, input logic [31:0] val,
                            input bit sync);
        list_cmd_t c;
        c.op   = op;
        c.pos  = pos;
        c.val  = val;
        c.sync = sync;
        // every 50 transactions, a run of 15 sent back to back
        c.gap  = (planned_cnt % 50 < 15) ? 0 : $urandom_range(0, 7);
        pending_cmds.push_back(c);
        planned_cnt++;
        if (op != OP_DUMP && !(op == OP_INSERT && int'(pos) > plan_occ) && plan_occ < CAPACITY)
            plan_occ++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Sender: offers the head of the pending queue after its idle gap and
    // predicts results on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            idle_cnt = 0;
        end
        else
        begin
            tx_next = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                apply_to_list(cur_cmd);
                sent_cnt <= sent_cnt + 1;
                tx_next = 1'b0;
            end
            if (!tx_next && pending_cmds.size() != 0)
            begin
                if (pending_cmds[0].sync && exp_count != got_count)
                    ;   // drain: wait for all outstanding results
                else if (idle_cnt < pending_cmds[0].gap)
                    idle_cnt++;
                else
                begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tdata <= {{(IN_W - VAL_W - POS_W){1'b0}}, cur_cmd.val, cur_cmd.pos};
                    s_tuser <= cur_cmd.op;
                    idle_cnt = 0;
                    tx_next  = 1'b1;
                end
            end
            s_tvalid <= tx_next;
        end
    end

    // Receiver: random stalls after each result, none for the first 32 of every 96 results,
    // and the long hold-off from rx_hold. Each accepted result is checked field by field.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            rdy_next = m_tready;
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("unexpected transaction, status", 32'(m_tuser), 32'd0);
                else
                begin
                    due = results_due.pop_front();
                    if (m_tuser != due.status)
                        report_mismatch("status", 32'(m_tuser), 32'(due.status));
                    if (m_tdata[31:0] != due.value)
                        report_mismatch("entry_value", m_tdata[31:0], due.value);
                    if (m_tlast != due.last)
                        report_mismatch("last_of_run", 32'(m_tlast), 32'(due.last));
                    if (m_tdata[38:32] != due.count)
                        report_mismatch("entry_count", 32'(m_tdata[38:32]), 32'(due.count));
                end
                got_count <= got_count + 1;
                stall_left = (got_count % 96 < 32) ? 0 : $urandom_range(0, 7);
                if (stall_left != 0)
                    rdy_next = 1'b0;
            end
            if (rx_hold)
                rdy_next = 1'b0;
            else if (!rdy_next)
            begin
                if (stall_left > 0)
                    stall_left--;
                else
                    rdy_next = 1'b1;
            end
            m_tready <= rdy_next;
        end
    end

    // Long receiver hold-off while the sender keeps offering, so the output
    // backs up and s_tready drops.
    initial
    begin
        while (sent_cnt < 60)
            @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        logic [6:0] pos;
        op_t        op;
        int         r;

        // Directed: empty dump, bad indexes, inserts at both ends and middle,
        // extreme values and positions.
        plan_cmd(OP_DUMP,   7'd0,   32'd0,        1'b0);
        plan_cmd(OP_INSERT, 7'd1,   32'h1234_5678, 1'b0);
        plan_cmd(OP_INSERT, 7'd127, 32'hFFFF_FFFF, 1'b0);
        plan_cmd(OP_INSERT, 7'd0,   32'h8000_0000, 1'b0);
        plan_cmd(OP_FRONT,  7'd127, 32'h7FFF_FFFF, 1'b0);
        plan_cmd(OP_BACK,   7'd0,   32'hFFFF_FFFF, 1'b0);
        plan_cmd(OP_BACK,   7'd127, 32'h0000_0000, 1'b0);
        plan_cmd(OP_INSERT, 7'd4,   32'hAAAA_AAAA, 1'b0);   // at occupancy: same as back
        plan_cmd(OP_INSERT, 7'd2,   32'h5555_5555, 1'b0);
        plan_cmd(OP_INSERT, 7'd7,   32'h0000_0001, 1'b0);   // one past the end
        plan_cmd(OP_INSERT, 7'd64,  32'h0000_0002, 1'b0);
        plan_cmd(OP_DUMP,   7'd127, 32'hFFFF_FFFF, 1'b0);
        plan_cmd(OP_INSERT, 7'd0,   32'hDEAD_BEEF, 1'b0);   // at zero: same as front
        plan_cmd(OP_FRONT,  7'd0,   32'h0000_0001, 1'b0);
        plan_cmd(OP_INSERT, 7'd5,   32'h8000_0001, 1'b0);
        plan_cmd(OP_DUMP,   7'd0,   32'd0,        1'b1);

        // Random: mostly in-range inserts and adds, some bad indexes and dumps.
        // The list fills up along the way, so the tail runs against a full list.
        for (int k = 0; k < 140; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                op = OP_FRONT;
            else if (r < 50)
                op = OP_BACK;
            else if (r < 80)
                op = OP_INSERT;
            else
                op = OP_DUMP;
            if (op != OP_INSERT)
                pos = 7'($urandom_range(0, 127));
            else if ($urandom_range(0, 9) < 8 || plan_occ >= 127)
                pos = 7'($urandom_range(0, plan_occ));
            else
                pos = 7'($urandom_range(plan_occ + 1, 127));
            plan_cmd(op, pos, pick_value(), k % 40 == 39);
        end

        // Make sure the list is full, then probe the full cases and dump all of it.
        while (plan_occ < CAPACITY)
            plan_cmd(OP_BACK, 7'($urandom_range(0, 127)), pick_value(), 1'b0);
        plan_cmd(OP_INSERT, 7'd64, $urandom, 1'b1);  // in range, but full
        plan_cmd(OP_INSERT, 7'd65, $urandom, 1'b0);  // bad index beats full
        plan_cmd(OP_FRONT,  7'd3,  $urandom, 1'b0);
        plan_cmd(OP_BACK,   7'd9,  $urandom, 1'b0);
        plan_cmd(OP_DUMP,   7'd0,  32'd0,    1'b0);

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_cnt != planned_cnt)
            @(posedge clk);
        while (got_count != exp_count)
            @(posedge clk);
        // then wait on to catch stray results
        repeat (20) @(posedge clk);
        if (results_due.size() != 0)
            report_mismatch("results never arrived", 32'(results_due.size()), 32'd0);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
